// ----- hdl/aff_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aff_pkg;

  // Frame buffer limit and field counter limit.
  localparam int BUF_BYTES  = 2048;
  localparam int MAX_FIELDS = 64;

  // Byte counter holds 0 up to BUF_BYTES; compares against the RTCM length
  // need at least eleven bits plus a guard bit.
  localparam int CNT_W = $clog2(BUF_BYTES + 1);
  localparam int CMP_W = ((CNT_W > 11) ? CNT_W : 11) + 1;
  localparam int SEP_W = 7;

  // Byte codes.
  localparam logic [7:0] SYNC_RTCM  = 8'hD3;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [24:0] CRC24Q_POLY = 25'h1864CFB;

  // Configuration register map.
  localparam int          PADDR_W         = 3;
  localparam logic [0:0]  REG_SUBTYPE_IDX = 1'b0;
  localparam logic [11:0] SUBTYPE_RESET   = 12'd4058;

  localparam logic FRAME_ASCII = 1'b0;
  localparam logic FRAME_RTCM  = 1'b1;

  // One result of the frame finder.
  typedef struct packed {
    logic             found;
    logic             frame_kind;
    logic             crc_error;
    logic [11:0]      message_type;
    logic [3:0]       message_subtype;
    logic [11:0]      frame_bytes;
    logic [SEP_W-1:0] field_count;
  } res_t;

  // CRC-24Q update for one byte, MSB first.
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC24Q_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/aff_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Received byte stream, one byte per item.
interface aff_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Completed frame report, one frame per item.
interface aff_result_if;
  logic        valid;
  logic        ready;
  logic        frame_kind;
  logic        crc_error;
  logic [11:0] message_type;
  logic [3:0]  message_subtype;
  logic [11:0] frame_bytes;
  logic [6:0]  field_count;

  modport source (output valid, output frame_kind, output crc_error, output message_type,
                  output message_subtype, output frame_bytes, output field_count,
                  input ready);
  modport sink (input valid, input frame_kind, input crc_error, input message_type,
                input message_subtype, input frame_bytes, input field_count,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/aff_apb_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aff_apb_regs
  import aff_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [11:0]        subtype_type_o
);

  logic [11:0] subtype_q;
  logic [11:0] subtype_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SUBTYPE_IDX);

  // Register write on the access phase.
  always_comb begin
    subtype_d = subtype_q;
    if (wr_en) begin
      subtype_d = pwdata[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subtype_q <= SUBTYPE_RESET;
    end else begin
      subtype_q <= subtype_d;
    end
  end

  // Read back; an address beyond the map reads as zero.
  always_comb begin
    prdata = 32'h0;
    if (paddr[2] == REG_SUBTYPE_IDX) begin
      prdata = {20'h00000, subtype_q};
    end
  end

  assign subtype_type_o = subtype_q;

endmodule

`default_nettype wire

// ----- hdl/aff_frame_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aff_frame_core
  import aff_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [11:0] subtype_type_i,
  output res_t             res_o
);

  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic             binary_q, binary_d;
  logic [23:0]      last3_q, last3_d;
  logic [31:0]      header_q, header_d;
  logic [23:0]      crc_q, crc_d;
  logic [23:0]      rcrc_q, rcrc_d;
  logic [SEP_W-1:0] sep_q, sep_d;

  logic [CNT_W-1:0] idx;
  logic [CMP_W-1:0] idx_w;
  logic [CMP_W-1:0] body;
  logic             go;
  logic             is_start;
  logic             bin;
  logic [31:0]      hdr;
  logic [23:0]      crc_cur;
  logic [23:0]      rcrc_cur;
  logic [SEP_W-1:0] sep_cur;
  logic [23:0]      last3_cur;
  logic             bad;
  logic [11:0]      msg_type;
  logic             is_end;
  logic             done;

  assign is_start = (rx_byte_i == CHAR_HASH) || (rx_byte_i == SYNC_RTCM);

  // Per-byte frame step: start checks, header capture, CRC and field count.
  always_comb begin
    byte_count_d = byte_count_q;
    binary_d     = binary_q;
    last3_d      = last3_q;
    header_d     = header_q;
    crc_d        = crc_q;
    rcrc_d       = rcrc_q;
    sep_d        = sep_q;
    res_o        = '0;

    go        = 1'b1;
    bin       = binary_q;
    hdr       = header_q;
    crc_cur   = crc_q;
    rcrc_cur  = rcrc_q;
    sep_cur   = sep_q;
    last3_cur = last3_q;
    bad       = 1'b0;
    msg_type  = 12'h000;
    is_end    = 1'b0;
    done      = 1'b0;
    idx_w     = '0;
    body      = '0;

    // A full buffer drops the frame and hunting restarts.
    idx = (byte_count_q >= CNT_W'(BUF_BYTES)) ? '0 : byte_count_q;

    if (step_i) begin
      byte_count_d = idx;
      if (idx == '0) begin
        if (!is_start) begin
          go = 1'b0;
        end else begin
          bin       = (rx_byte_i == SYNC_RTCM);
          hdr       = 32'h0;
          crc_cur   = 24'h0;
          rcrc_cur  = 24'h0;
          sep_cur   = '0;
          last3_cur = 24'h0;
        end
      end else if ((idx < CNT_W'(3)) && !binary_q) begin
        if (rx_byte_i != ((idx == CNT_W'(1)) ? CHAR_A : CHAR_P)) begin
          go           = 1'b0;
          byte_count_d = '0;
        end
      end

      if (go) begin
        // Header bytes one to four.
        if (idx == CNT_W'(1)) hdr[31:24] = rx_byte_i;
        if (idx == CNT_W'(2)) hdr[23:16] = rx_byte_i;
        if (idx == CNT_W'(3)) hdr[15:8]  = rx_byte_i;
        if (idx == CNT_W'(4)) hdr[7:0]   = rx_byte_i;

        idx_w = CMP_W'(idx);
        body  = CMP_W'({hdr[25:24], hdr[23:16]}) + CMP_W'(3);

        if (bin) begin
          // Body bytes feed the CRC, the last three are the received CRC.
          if ((idx < CNT_W'(3)) || (idx_w < body)) begin
            crc_cur = crc24q_byte(crc_cur, rx_byte_i);
          end else begin
            rcrc_cur = {rcrc_cur[15:0], rx_byte_i};
          end
          msg_type = hdr[15:4];
          bad      = (crc_cur != rcrc_cur);
          if ((idx >= CNT_W'(3)) && ((idx_w + CMP_W'(1)) >= (body + CMP_W'(3)))) begin
            done                  = 1'b1;
            res_o.frame_kind      = FRAME_RTCM;
            res_o.crc_error       = bad;
            res_o.message_type    = msg_type;
            res_o.message_subtype = (!bad && (msg_type == subtype_type_i)) ? hdr[3:0] : 4'h0;
          end
        end else if (idx >= CNT_W'(3)) begin
          // Commas count fields; CR or LF after the checksum marker ends it.
          is_end = ((rx_byte_i == CHAR_CR) || (rx_byte_i == CHAR_LF)) &&
                   (last3_cur[23:16] == CHAR_STAR);
          if (((rx_byte_i == CHAR_COMMA) || is_end) && (sep_cur < SEP_W'(MAX_FIELDS))) begin
            sep_cur = sep_cur + SEP_W'(1);
          end
          if (is_end) begin
            done              = 1'b1;
            res_o.frame_kind  = FRAME_ASCII;
            res_o.field_count = sep_cur;
          end
        end

        res_o.found       = done;
        res_o.frame_bytes = 12'(idx_w + CMP_W'(1));

        binary_d     = bin;
        header_d     = hdr;
        crc_d        = crc_cur;
        rcrc_d       = rcrc_cur;
        sep_d        = sep_cur;
        last3_d      = {last3_cur[15:0], rx_byte_i};
        byte_count_d = done ? '0 : (idx + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      binary_q     <= 1'b0;
      last3_q      <= 24'h0;
      header_q     <= 32'h0;
      crc_q        <= 24'h0;
      rcrc_q       <= 24'h0;
      sep_q        <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      binary_q     <= binary_d;
      last3_q      <= last3_d;
      header_q     <= header_d;
      crc_q        <= crc_d;
      rcrc_q       <= rcrc_d;
      sep_q        <= sep_d;
    end
  end

  // The byte counter never passes the buffer limit.
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CNT_W'(BUF_BYTES))
    else $error("byte counter beyond buffer limit");

  // The field counter saturates.
  a_sep_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sep_q <= SEP_W'(MAX_FIELDS))
    else $error("field counter beyond limit");

  // After a result the block hunts again.
  a_hunt_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.found |=> (byte_count_q == '0))
    else $error("byte counter not cleared after result");

  // A dropped byte while hunting leaves the history untouched.
  a_drop_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (idx == '0) && !is_start) |=> ($stable(last3_q) && (byte_count_q == '0)))
    else $error("dropped byte changed frame state");

  // Nothing is reported without a byte being processed.
  a_result_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.found |-> step_i)
    else $error("result without input byte");

endmodule

`default_nettype wire

// ----- hdl/ascii_and_rtcm3_frame_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Flow: an accepted byte waits in the input register, is processed when the result register
// is free or being emptied, and its result is then held in the result register.
// Throughput: one byte per cycle; the input register and result register only stall
// when a pending result is not taken.
// Reset: rst_ni clears all frame state asynchronously and the block starts hunting.

module ascii_and_rtcm3_frame_finder
  import aff_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  aff_byte_if.sink                byte_i,
  aff_result_if.source            result_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q, in_byte_d;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;
  res_t        core_res;
  logic        advance;
  logic        in_take;
  logic [11:0] subtype_type;

  aff_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .subtype_type_o (subtype_type)
  );

  // A held byte moves on when the result register is free or being emptied.
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign byte_i.ready = !in_valid_q || advance;
  assign in_take      = byte_i.valid && byte_i.ready;

  aff_frame_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .rx_byte_i      (in_byte_q),
    .subtype_type_i (subtype_type),
    .res_o          (core_res)
  );

  // Input register.
  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (in_take) begin
      in_valid_d = 1'b1;
      in_byte_d  = byte_i.rx_byte;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = core_res.found;
      out_d       = core_res;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_q     <= out_d;
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.frame_kind      = out_q.frame_kind;
  assign result_o.crc_error       = out_q.crc_error;
  assign result_o.message_type    = out_q.message_type;
  assign result_o.message_subtype = out_q.message_subtype;
  assign result_o.frame_bytes     = out_q.frame_bytes;
  assign result_o.field_count     = out_q.field_count;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import aff_pkg::*;

  // One frame report as it leaves the block.
  typedef struct packed {
    logic        frame_kind;
    logic        crc_error;
    logic [11:0] message_type;
    logic [3:0]  message_subtype;
    logic [11:0] frame_bytes;
    logic [6:0]  field_count;
  } frame_rpt_t;

  localparam logic [PADDR_W-1:0] SUBTYPE_ADDR = PADDR_W'(4 * REG_SUBTYPE_IDX);
  localparam string HEX_DIGITS = "0123456789ABCDEF";

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  aff_byte_if   byte_if ();
  aff_result_if res_if ();

  ascii_and_rtcm3_frame_finder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // Frame hunter state as seen from the byte stream.
  int          fr_len = 0;
  logic        fr_binary = 1'b0;
  logic [23:0] last3 = '0;
  logic [31:0] hdr_word = '0;
  logic [23:0] crc_run = '0;
  logic [23:0] crc_got = '0;
  logic [6:0]  sep_cnt = '0;
  logic [11:0] cfg_subtype_type = SUBTYPE_RESET;

  frame_rpt_t pending_frames[$];

  bit src_idle = 1'b0;
  bit snk_idle = 1'b0;
  int mismatch_cnt = 0;
  int n_bytes = 0;
  int seq_bytes = 0;
  int n_ascii = 0;
  int n_rtcm = 0;
  int n_crc_err = 0;
  int n_settings = 0;

  // CRC-24Q, one data bit at a time from the most significant end.
  function automatic logic [23:0] crc24q_step(input logic [23:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[23] ^ d[i];
      c = {c[22:0], 1'b0};
      if (fb) begin
        c = c ^ CRC24Q_POLY[23:0];
      end
    end
    return c;
  endfunction

  // Advances the hunter by one byte and reports a finished frame, if any.
  function automatic void predict_rx_byte(input logic [7:0] b, output bit got,
                                          output frame_rpt_t r);
    int pos;
    int body;
    got = 1'b0;
    r = '0;
    if (fr_len >= BUF_BYTES) begin
      fr_len = 0;
    end
    if (fr_len == 0) begin
      if (b != CHAR_HASH && b != SYNC_RTCM) begin
        return;
      end
      fr_binary = (b == SYNC_RTCM);
      last3 = '0;
      hdr_word = '0;
      crc_run = '0;
      crc_got = '0;
      sep_cnt = '0;
    end else if (fr_len < 3 && !fr_binary) begin
      if (b != ((fr_len == 1) ? CHAR_A : CHAR_P)) begin
        fr_len = 0;
        return;
      end
    end
    pos = fr_len;
    if (pos >= 1 && pos <= 4) begin
      hdr_word = hdr_word | ({24'h0, b} << ((4 - pos) * 8));
    end
    if (fr_binary) begin
      body = int'(hdr_word[25:16]) + 3;
      if (pos < 3 || pos < body) begin
        crc_run = crc24q_step(crc_run, b);
      end else begin
        crc_got = {crc_got[15:0], b};
      end
      if (pos >= 3 && pos + 1 >= body + 3) begin
        got = 1'b1;
        r.frame_kind = FRAME_RTCM;
        r.crc_error = (crc_run != crc_got);
        r.message_type = hdr_word[15:4];
        if (!r.crc_error && hdr_word[15:4] == cfg_subtype_type) begin
          r.message_subtype = hdr_word[3:0];
        end
        r.frame_bytes = 12'(pos + 1);
      end
    end else if (pos >= 3) begin
      if (b == CHAR_COMMA && sep_cnt < MAX_FIELDS) begin
        sep_cnt = sep_cnt + 1'b1;
      end
      if ((b == CHAR_CR || b == CHAR_LF) && last3[23:16] == CHAR_STAR) begin
        if (sep_cnt < MAX_FIELDS) begin
          sep_cnt = sep_cnt + 1'b1;
        end
        got = 1'b1;
        r.frame_kind = FRAME_ASCII;
        r.frame_bytes = 12'(pos + 1);
        r.field_count = sep_cnt;
      end
    end
    last3 = {last3[15:0], b};
    fr_len = got ? 0 : pos + 1;
  endfunction

  // Offers one byte after a random gap and records what it should produce.
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    bit got;
    frame_rpt_t r;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.rx_byte <= b;
    do @(posedge clk_i); while (!(byte_if.valid === 1'b1 && byte_if.ready === 1'b1));
    predict_rx_byte(b, got, r);
    if (got) begin
      pending_frames.push_back(r);
    end
    n_bytes++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) begin
      send_rx_byte(q[i]);
    end
  endtask

  // ASCII sentence with a random body; end_sel picks CR, LF or CR then LF.
  task automatic send_ascii(input int body_len, input int end_sel);
    logic [7:0] q[$];
    q = '{CHAR_HASH, CHAR_A, CHAR_P};
    for (int k = 0; k < body_len; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        q.push_back(CHAR_COMMA);
      end else begin
        q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
    q.push_back(CHAR_STAR);
    q.push_back(HEX_DIGITS[$urandom_range(0, 15)]);
    q.push_back(HEX_DIGITS[$urandom_range(0, 15)]);
    q.push_back((end_sel == 1) ? CHAR_LF : CHAR_CR);
    if (end_sel == 2) begin
      q.push_back(CHAR_LF);
    end
    seq_bytes += q.size();
    send_bytes(q);
  endtask

  // RTCM3 frame with a proper CRC, optionally with one bit flipped after the length.
  task automatic send_rtcm(input int len, input logic [11:0] typ, input logic [3:0] sub,
                           input bit corrupt);
    logic [7:0] q[$];
    logic [9:0] l10;
    logic [23:0] c;
    int k;
    l10 = len[9:0];
    q = '{SYNC_RTCM, {6'($urandom), l10[9:8]}, l10[7:0]};
    for (int j = 0; j < len; j++) begin
      if (j == 0) begin
        q.push_back(typ[11:4]);
      end else if (j == 1) begin
        q.push_back({typ[3:0], sub});
      end else begin
        q.push_back(8'($urandom));
      end
    end
    c = '0;
    foreach (q[i]) begin
      c = crc24q_step(c, q[i]);
    end
    q.push_back(c[23:16]);
    q.push_back(c[15:8]);
    q.push_back(c[7:0]);
    if (corrupt) begin
      k = $urandom_range(3, q.size() - 1);
      q[k] = q[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    seq_bytes += q.size();
    send_bytes(q);
  endtask

  // Broken starts and stray bytes.
  task automatic send_noise();
    logic [7:0] q[$];
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
      end
      1: begin
        b = 8'($urandom);
        q = '{CHAR_HASH, (b == CHAR_A) ? CHAR_P : b};
      end
      2: begin
        b = 8'($urandom);
        q = '{CHAR_HASH, CHAR_A, (b == CHAR_P) ? CHAR_A : b};
      end
      default: begin
        q = '{CHAR_HASH, CHAR_A, CHAR_P};
        repeat ($urandom_range(0, 5)) q.push_back(8'($urandom));
      end
    endcase
    send_bytes(q);
  endtask

  // Lets every expected report arrive, then waits on so the block is idle.
  task automatic wait_results_done();
    byte_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_subtype_type(input logic [11:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SUBTYPE_ADDR;
    pwdata <= {20'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_subtype_type = v;
    n_settings++;
  endtask

  task automatic check_result(input frame_rpt_t seen);
    frame_rpt_t want;
    if (pending_frames.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t: report with no frame pending: kind %0d bytes %0d", $realtime,
                 seen.frame_kind, seen.frame_bytes);
      end
      return;
    end
    want = pending_frames.pop_front();
    if (seen !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t: expected kind %0d crc_err %0d type %0d sub %0d bytes %0d fields %0d",
                 $realtime, want.frame_kind, want.crc_error, want.message_type,
                 want.message_subtype, want.frame_bytes, want.field_count);
        $display("%0t:   actual kind %0d crc_err %0d type %0d sub %0d bytes %0d fields %0d",
                 $realtime, seen.frame_kind, seen.crc_error, seen.message_type,
                 seen.message_subtype, seen.frame_bytes, seen.field_count);
      end
    end
    if (want.frame_kind == FRAME_RTCM) begin
      n_rtcm++;
      n_crc_err += want.crc_error;
    end else begin
      n_ascii++;
    end
  endtask

  // Short hand-built stream: stray bytes, broken starts, both frame kinds.
  task automatic test_directed();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_bytes('{8'h00, 8'hFF});
    // The second hash is dropped, not taken as a new start, so A and P are strays.
    send_bytes('{CHAR_HASH, CHAR_HASH, CHAR_A, CHAR_P});
    send_bytes('{CHAR_HASH, CHAR_A, CHAR_P, CHAR_STAR, 8'h30, 8'h30, CHAR_LF});
    send_bytes('{CHAR_HASH, CHAR_A, CHAR_P, CHAR_COMMA, CHAR_COMMA, CHAR_STAR, 8'h46,
                 8'h46, CHAR_CR});
    // Zero-length RTCM frame: the type bits come from the CRC bytes.
    send_rtcm(0, 12'h000, 4'h0, 1'b0);
    wait_results_done();
  endtask

  // Subtype extraction against the register, extreme types and lengths.
  task automatic test_rtcm_types();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_rtcm(6, SUBTYPE_RESET, 4'h9, 1'b0);
    send_rtcm(1, SUBTYPE_RESET, 4'h5, 1'b0);
    send_rtcm(2, SUBTYPE_RESET, 4'hF, 1'b0);
    wait_results_done();
    write_subtype_type(12'h000);
    send_rtcm(8, 12'h000, 4'hF, 1'b0);
    send_rtcm(8, 12'h000, 4'hF, 1'b1);
    send_rtcm(8, 12'h001, 4'hA, 1'b0);
    wait_results_done();
    write_subtype_type(12'hFFF);
    send_rtcm(5, 12'hFFF, 4'hF, 1'b0);
    send_rtcm(5, 12'hFFE, 4'hF, 1'b0);
    send_rtcm(1023, 12'hFFF, 4'h3, 1'b0);
    wait_results_done();
  endtask

  // Comma counter just reaching and going past its limit.
  task automatic test_field_limit();
    logic [7:0] q[$];
    src_idle = 1'b0;
    snk_idle = 1'b1;
    foreach (q[i]) q.delete();
    q = '{CHAR_HASH, CHAR_A, CHAR_P};
    repeat (MAX_FIELDS - 1) q.push_back(CHAR_COMMA);
    q.push_back(CHAR_STAR);
    q.push_back(8'h31);
    q.push_back(8'h32);
    q.push_back(CHAR_LF);
    send_bytes(q);
    q = '{CHAR_HASH, CHAR_A, CHAR_P};
    repeat (MAX_FIELDS + 6) q.push_back(CHAR_COMMA);
    q.push_back(CHAR_STAR);
    q.push_back(8'h41);
    q.push_back(8'h42);
    q.push_back(CHAR_CR);
    send_bytes(q);
    wait_results_done();
  endtask

  // A sentence that fills the buffer exactly, and one that overruns it.
  task automatic test_buffer_limit();
    logic [7:0] q[$];
    src_idle = 1'b1;
    snk_idle = 1'b0;
    q = '{CHAR_HASH, CHAR_A, CHAR_P};
    while (q.size() < BUF_BYTES - 4) begin
      q.push_back(($urandom_range(0, 7) == 0) ? CHAR_COMMA : 8'($urandom_range(8'h41, 8'h5A)));
    end
    q.push_back(CHAR_STAR);
    q.push_back(8'h30);
    q.push_back(8'h30);
    q.push_back(CHAR_CR);
    send_bytes(q);
    // The overrun frame ends in a star pattern; the LF after it is a hunting byte.
    q = '{CHAR_HASH, CHAR_A, CHAR_P};
    while (q.size() < BUF_BYTES - 3) begin
      q.push_back(8'($urandom_range(8'h41, 8'h5A)));
    end
    q.push_back(CHAR_STAR);
    q.push_back(8'h30);
    q.push_back(8'h30);
    q.push_back(CHAR_LF);
    send_bytes(q);
    send_bytes('{CHAR_HASH, CHAR_A, CHAR_P, CHAR_COMMA, CHAR_STAR, 8'h37, 8'h37, CHAR_LF});
    wait_results_done();
  endtask

  // Mostly well-formed frames with random content, some noise, several settings.
  task automatic test_random_traffic();
    logic [11:0] setting_list[5];
    logic [11:0] typ;
    int start;
    int pick;
    int len;
    bit paused;
    paused = 1'b0;
    setting_list = '{SUBTYPE_RESET, 12'h000, 12'hFFF, 12'($urandom), 12'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      wait_results_done();
      write_subtype_type(setting_list[ph]);
      src_idle = (ph == 1 || ph == 2 || ph == 4);
      snk_idle = (ph == 1 || ph == 3 || ph == 4);
      start = seq_bytes;
      while (seq_bytes - start < 400) begin
        // Once, the sender holds off until the block has reported everything.
        if (ph == 2 && !paused && seq_bytes - start >= 200) begin
          wait_results_done();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_ascii($urandom_range(0, 30), $urandom_range(0, 2));
        end else if (pick < 75) begin
          len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 120);
          typ = $urandom_range(0, 1) ? cfg_subtype_type : 12'($urandom);
          send_rtcm(len, typ, 4'($urandom), $urandom_range(0, 4) == 0);
        end else begin
          send_noise();
        end
      end
    end
  endtask

  // Result side: random stalls, every report checked in order.
  initial begin : result_checker
    frame_rpt_t seen;
    int gap;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = snk_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
      seen.frame_kind = res_if.frame_kind;
      seen.crc_error = res_if.crc_error;
      seen.message_type = res_if.message_type;
      seen.message_subtype = res_if.message_subtype;
      seen.frame_bytes = res_if.frame_bytes;
      seen.field_count = res_if.field_count;
      check_result(seen);
    end
  end

  initial begin
    rst_ni <= 1'b0;
    byte_if.valid <= 1'b0;
    byte_if.rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_rtcm_types();
    test_field_limit();
    test_buffer_limit();
    test_random_traffic();
    wait_results_done();
    $display("Streamed %0d bytes; %0d ASCII and %0d RTCM3 reports checked, %0d with bad CRC.",
             n_bytes, n_ascii, n_rtcm, n_crc_err);
    $display("Subtype register written %0d times; %0d mismatches.", n_settings, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[ascii_and_rtcm3_frame_finder] OK");
    end else begin
      $display("[ascii_and_rtcm3_frame_finder] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("Timed out with %0d reports still pending.", pending_frames.size());
    $display("[ascii_and_rtcm3_frame_finder] ERROR");
    $finish;
  end

endmodule
